// ===== design/calendar_time_counter_top_macros.svh =====
// Assertion macros for the calendar time counter top module.
`ifndef CALENDAR_TIME_COUNTER_TOP_MACROS_SVH
`define CALENDAR_TIME_COUNTER_TOP_MACROS_SVH

// Checked assertion on clk, disabled while arst_n is low.
`define CTC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked assertion on clk that also holds during reset.
`define CTC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/ctc_pkg.sv =====
// Package with the types, constants and month table of the calendar time counter.
package ctc_pkg;

	localparam int unsigned YearW = 16;
	localparam int unsigned CfgIdxW = 1;

	localparam logic [5:0] SecLast = 6'd59;
	localparam logic [5:0] MinLast = 6'd59;
	localparam logic [4:0] HourLast = 5'd23;
	localparam logic [3:0] MonthLast = 4'd12;
	localparam logic [3:0] MonthFirst = 4'd1;
	localparam logic [4:0] DayFirst = 5'd1;

	localparam logic [YearW-1:0] ResetYear = 16'd2015;
	localparam logic [YearW-1:0] ResetMinYear = 16'd2000;
	localparam logic [YearW-1:0] ResetMaxYear = 16'd2100;

	localparam logic [CfgIdxW-1:0] RegMinYear = 1'b0;
	localparam logic [CfgIdxW-1:0] RegMaxYear = 1'b1;

	localparam logic [0:0] ModeTick = 1'b0;
	localparam logic [0:0] ModeSet = 1'b1;

	typedef struct packed {
		logic [YearW-1:0] year;
		logic [3:0]       month;
		logic [4:0]       day;
		logic [4:0]       hour;
		logic [5:0]       minute;
		logic [5:0]       second;
	} cal_t;

	typedef struct packed {
		logic             mode;
		logic [5:0]       new_second;
		logic [5:0]       new_minute;
		logic [4:0]       new_hour;
		logic [4:0]       new_day;
		logic [3:0]       new_month;
		logic [YearW-1:0] new_year;
	} req_t;

	typedef struct packed {
		logic [5:0]       cur_second;
		logic [5:0]       cur_minute;
		logic [4:0]       cur_hour;
		logic [4:0]       cur_day;
		logic [3:0]       cur_month;
		logic [YearW-1:0] cur_year;
		logic             set_rejected;
	} rsp_t;

	typedef struct packed {
		logic [CfgIdxW-1:0] index;
		logic [YearW-1:0]   value;
	} cfg_t;

	// Days per month, February fixed at 28; codes outside 1 to 12 give zero.
	function automatic logic [4:0] month_len(input logic [3:0] month);
		logic [4:0] len;
		case (month)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			4'd2: len = 5'd28;
			default: len = 5'd0;
		endcase
		return len;
	endfunction

endpackage

// ===== design/ctc_stream_if.sv =====
// Valid/ready channel interface with a typed payload.
interface ctc_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/calendar_time_counter_top.sv =====
// Calendar time counter: tick and set handling with a registered result channel.
// Usage:
//   req carries one item per handshake: mode 0 is a one-second tick, mode 1 sets
//   the time from the new_* fields after a range check of all fields and the year window.
//   rsp returns one item per request with the time after it and a reject flag.
//   cfg writes register 0 (min_year) or 1 (max_year); it is always ready. The user must
//   see that it is written only while no request is in flight; the block does not enforce it.
// Result: registered; it appears on rsp in the cycle after the request is accepted.
// Throughput: one item per cycle while rsp is not stalled; the calendar registers and
//   the carry and check logic in front of them are updated in the accept cycle.
// Reset: the time goes to 00:00:00 on January 1st 2015, the window to 2000..2100,
//   and rsp holds no item.
// Stall: while rsp is stalled the result register holds its item and req stays
//   ready only if the held item is taken in the same cycle.
`include "calendar_time_counter_top_macros.svh"

module calendar_time_counter_top (
	input logic       clk,
	input logic       arst_n,
	ctc_stream_if.sink   req,
	ctc_stream_if.source rsp,
	ctc_stream_if.sink   cfg
);

	ctc_pkg::cal_t                   cal_q;
	ctc_pkg::cal_t                   cal_tick;
	ctc_pkg::cal_t                   cal_next;
	ctc_pkg::cal_t                   cal_set;
	logic [ctc_pkg::YearW-1:0]       min_year_q;
	logic [ctc_pkg::YearW-1:0]       max_year_q;
	logic                            rsp_valid_q;
	ctc_pkg::rsp_t                   rsp_data_q;
	logic                            req_acc;
	logic                            set_ok;
	logic                            rejected;
	logic                            sec_wrap;
	logic                            min_wrap;
	logic                            hour_wrap;
	logic                            day_wrap;
	logic                            month_wrap;
	logic [5:0]                      day_inc;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign req_acc = req.valid && req.ready;
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data = rsp_data_q;

	always_comb begin
		sec_wrap = (cal_q.second == ctc_pkg::SecLast);
		min_wrap = sec_wrap && (cal_q.minute == ctc_pkg::MinLast);
		hour_wrap = min_wrap && (cal_q.hour == ctc_pkg::HourLast);
		day_inc = {1'b0, cal_q.day} + 6'd1;
		day_wrap = hour_wrap && (day_inc > {1'b0, ctc_pkg::month_len(cal_q.month)});
		month_wrap = day_wrap && (cal_q.month >= ctc_pkg::MonthLast);

		cal_tick = cal_q;
		cal_tick.second = sec_wrap ? 6'd0 : cal_q.second + 6'd1;
		if (sec_wrap) begin
			cal_tick.minute = min_wrap ? 6'd0 : cal_q.minute + 6'd1;
		end
		if (min_wrap) begin
			cal_tick.hour = hour_wrap ? 5'd0 : cal_q.hour + 5'd1;
		end
		if (hour_wrap) begin
			cal_tick.day = day_wrap ? ctc_pkg::DayFirst : day_inc[4:0];
		end
		if (day_wrap) begin
			cal_tick.month = month_wrap ? ctc_pkg::MonthFirst : cal_q.month + 4'd1;
		end
		if (month_wrap) begin
			cal_tick.year = cal_q.year + 16'd1;
		end

		cal_set.second = req.data.new_second;
		cal_set.minute = req.data.new_minute;
		cal_set.hour = req.data.new_hour;
		cal_set.day = req.data.new_day;
		cal_set.month = req.data.new_month;
		cal_set.year = req.data.new_year;

		set_ok = (req.data.new_second <= ctc_pkg::SecLast)
			&& (req.data.new_minute <= ctc_pkg::MinLast)
			&& (req.data.new_hour <= ctc_pkg::HourLast)
			&& (req.data.new_month >= ctc_pkg::MonthFirst)
			&& (req.data.new_month <= ctc_pkg::MonthLast)
			&& (req.data.new_day >= ctc_pkg::DayFirst)
			&& (req.data.new_day <= ctc_pkg::month_len(req.data.new_month))
			&& (req.data.new_year >= min_year_q)
			&& (req.data.new_year <= max_year_q);

		if (req.data.mode == ctc_pkg::ModeTick) begin
			cal_next = cal_tick;
			rejected = 1'b0;
		end else if (set_ok) begin
			cal_next = cal_set;
			rejected = 1'b0;
		end else begin
			cal_next = cal_q;
			rejected = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q.second <= 6'd0;
			cal_q.minute <= 6'd0;
			cal_q.hour <= 5'd0;
			cal_q.day <= ctc_pkg::DayFirst;
			cal_q.month <= ctc_pkg::MonthFirst;
			cal_q.year <= ctc_pkg::ResetYear;
			min_year_q <= ctc_pkg::ResetMinYear;
			max_year_q <= ctc_pkg::ResetMaxYear;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.data.index)
					ctc_pkg::RegMinYear: min_year_q <= cfg.data.value;
					ctc_pkg::RegMaxYear: max_year_q <= cfg.data.value;
					default: ;
				endcase
			end
			if (req_acc) begin
				cal_q <= cal_next;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			rsp_data_q.cur_second <= cal_next.second;
			rsp_data_q.cur_minute <= cal_next.minute;
			rsp_data_q.cur_hour <= cal_next.hour;
			rsp_data_q.cur_day <= cal_next.day;
			rsp_data_q.cur_month <= cal_next.month;
			rsp_data_q.cur_year <= cal_next.year;
			rsp_data_q.set_rejected <= rejected;
		end
	end

	`CTC_ASSERT(a_acc_gives_rsp, req_acc |=> rsp_valid_q, "accepted item produced no result")
	`CTC_ASSERT(a_reject_holds, req_acc && rejected |=> $stable(cal_q), "rejected set changed the time")
	`CTC_ASSERT(a_tick_not_rejected, req_acc && !req.data.mode |-> !rejected, "tick flagged as rejected")
	`CTC_ASSERT_ALWAYS(a_empty_ready, !rsp_valid_q |-> req.ready, "request stalled with empty result register")
	`CTC_ASSERT(a_cal_legal, (cal_q.second <= ctc_pkg::SecLast) && (cal_q.hour <= ctc_pkg::HourLast) && (cal_q.month >= ctc_pkg::MonthFirst) && (cal_q.month <= ctc_pkg::MonthLast) && (cal_q.day >= ctc_pkg::DayFirst), "calendar state out of range")

endmodule
